// ===== rtl/gab_pkg.sv =====
`timescale 1ns / 1ps
package gab_pkg;

  localparam int ATLAS_BYTES_DEF   = 4096;
  localparam int GLYPH_SLOTS_DEF   = 256;
  localparam int MAX_GLYPH_DIM_DEF = 8;

  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int OUT_ALPHA_LSB = 50;
  localparam int OUT_ADV_LSB   = 58;

  localparam logic [1:0] KIND_ATLAS = 2'd0;
  localparam logic [1:0] KIND_GLYPH = 2'd1;
  localparam logic [1:0] KIND_DRAW  = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_CODE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LAST_CODE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ATLAS_COLS = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ATLAS_ROWS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TEXT_RGB   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TEXT_ALPHA = 3'd5;

  localparam logic [7:0]  SPACE_CODE  = 8'd32;
  localparam logic [16:0] ALPHA_ROUND = 17'd127;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0]        adv;
    logic signed [7:0] oy;
    logic signed [7:0] ox;
    logic [3:0]        h;
    logic [3:0]        w;
    logic [11:0]       row;
    logic [11:0]       col;
  } glyph_t;

  localparam int GLYPH_W = $bits(glyph_t);

endpackage

// ===== rtl/gab_ram.sv =====
`timescale 1ns / 1ps
module gab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/glyph_atlas_blitter_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Width  Contents
// s_axis    in   104+2  load or draw word; kind in tuser
// m_axis    out  72+1   pixel word; pixel_valid in tuser, last in tlast
// cfg       in   3+24   register write, no read-back
//
// A load is written directly. A draw with a glyph: glyph table read, setup, a walk of one
// glyph pixel per cycle via the coverage RAM read port unless frozen, pipeline drain, final
// word. No glyph: straight to the final word; zero atlas or glyph size: to it after setup.
// Output stalls freeze the pixel pipeline once a pixel is held back for last marking.
// Input is taken only while no draw is in progress; a finished word may still wait.
// Reset (rst, synchronous) restores registers and control; memories stay undefined.
module glyph_atlas_blitter_unit
  import gab_pkg::*;
#(
  parameter int ATLAS_BYTES   = ATLAS_BYTES_DEF,
  parameter int GLYPH_SLOTS   = GLYPH_SLOTS_DEF,
  parameter int MAX_GLYPH_DIM = MAX_GLYPH_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot, byte_in, src_col, src_row, glyph_w, glyph_h, offset_x, offset_y, advance_in,
  // pen_x, pen_y
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_x, pixel_y, pixel_rgb, pixel_alpha, advance_out
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // pixel_valid
  output logic [0:0]            m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (ATLAS_BYTES > 1) ? $clog2(ATLAS_BYTES) : 1;
  localparam int SW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam logic [3:0] MAX_DIM = 4'(MAX_GLYPH_DIM);

  logic [7:0]  first_code, last_code, text_alpha;
  logic [12:0] atlas_cols, atlas_rows;
  logic [23:0] text_rgb;

  logic [1:0]  in_kind;
  logic [11:0] in_slot, in_src_col, in_src_row, in_pen_x, in_pen_y;
  logic [7:0]  in_byte, in_offset_x, in_offset_y, in_advance;
  logic [3:0]  in_glyph_w, in_glyph_h;

  assign in_kind     = s_axis_tuser;
  assign in_slot     = s_axis_tdata[11:0];
  assign in_byte     = s_axis_tdata[19:12];
  assign in_src_col  = s_axis_tdata[31:20];
  assign in_src_row  = s_axis_tdata[43:32];
  assign in_glyph_w  = s_axis_tdata[47:44];
  assign in_glyph_h  = s_axis_tdata[51:48];
  assign in_offset_x = s_axis_tdata[59:52];
  assign in_offset_y = s_axis_tdata[67:60];
  assign in_advance  = s_axis_tdata[75:68];
  assign in_pen_x    = s_axis_tdata[87:76];
  assign in_pen_y    = s_axis_tdata[99:88];

  state_t state, state_next;

  logic s_fire, out_free, en;
  logic code_in_range, space_in_range, lk_hit;
  logic [7:0] lk_idx;

  glyph_t g_wdata, g_rd;
  logic [GLYPH_W-1:0] g_rdata;
  logic g_we, g_re, cov_we, cov_re;
  logic [7:0] cov_rdata;

  logic [11:0] pen_x, pen_y, g_col;
  logic [3:0]  gx, gy, gw, gh;
  logic [12:0] cur_sx, cur_sy;
  logic [25:0] row_addr, row_mult;
  logic [13:0] base_x, base_y, pos_dx, pos_dy;
  logic [7:0]  adv;
  logic [26:0] rd_addr;
  logic        pos_ok, row_end, last_pos;

  logic        p2_valid, p3_valid;
  logic [12:0] p2_dx, p2_dy, p3_dx, p3_dy;
  logic [15:0] p3_prod;
  logic [16:0] alpha_sum, alpha_q;
  logic [7:0]  p3_alpha;
  logic        px_fire, finish_load;

  logic        pend_valid;
  logic [12:0] pend_x, pend_y;
  logic [7:0]  pend_alpha;

  logic        out_pv, out_last;
  logic [12:0] out_x, out_y;
  logic [23:0] out_rgb;
  logic [7:0]  out_alpha, out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_code <= 8'd32;
      last_code  <= 8'd126;
      atlas_cols <= '0;
      atlas_rows <= '0;
      text_rgb   <= 24'hFFFFFF;
      text_alpha <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FIRST_CODE: first_code <= cfg_data[7:0];
        REG_LAST_CODE:  last_code  <= cfg_data[7:0];
        REG_ATLAS_COLS: atlas_cols <= cfg_data[12:0];
        REG_ATLAS_ROWS: atlas_rows <= cfg_data[12:0];
        REG_TEXT_RGB:   text_rgb   <= cfg_data;
        REG_TEXT_ALPHA: text_alpha <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign en       = !pend_valid || out_free;

  assign code_in_range  = (in_byte >= first_code) && (in_byte <= last_code);
  assign space_in_range = (SPACE_CODE >= first_code) && (SPACE_CODE <= last_code);
  assign lk_idx = code_in_range ? (in_byte - first_code) : (SPACE_CODE - first_code);
  assign lk_hit = (code_in_range || space_in_range) && (32'(lk_idx) < GLYPH_SLOTS);

  always_comb begin
    g_wdata     = '0;
    g_wdata.col = in_src_col;
    g_wdata.row = in_src_row;
    g_wdata.w   = (in_glyph_w > MAX_DIM) ? MAX_DIM : in_glyph_w;
    g_wdata.h   = (in_glyph_h > MAX_DIM) ? MAX_DIM : in_glyph_h;
    g_wdata.ox  = in_offset_x;
    g_wdata.oy  = in_offset_y;
    g_wdata.adv = in_advance;
  end

  assign g_we   = s_fire && (in_kind == KIND_GLYPH) && (32'(in_slot) < GLYPH_SLOTS);
  assign g_re   = s_fire && (in_kind == KIND_DRAW) && lk_hit;
  assign cov_we = s_fire && (in_kind == KIND_ATLAS) && (32'(in_slot) < ATLAS_BYTES);
  assign g_rd   = glyph_t'(g_rdata);

  gab_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (GLYPH_SLOTS)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (SW'(in_slot)),
    .wdata (g_wdata),
    .re    (g_re),
    .raddr (SW'(lk_idx)),
    .rdata (g_rdata)
  );

  gab_ram #(
    .WIDTH (8),
    .DEPTH (ATLAS_BYTES)
  ) u_cov_ram (
    .clk   (clk),
    .we    (cov_we),
    .waddr (AW'(in_slot)),
    .wdata (in_byte),
    .re    (cov_re),
    .raddr (rd_addr[AW-1:0]),
    .rdata (cov_rdata)
  );

  assign row_mult = 26'(g_rd.row) * 26'(atlas_cols);
  assign rd_addr  = 27'(row_addr) + 27'(cur_sx);
  assign pos_dx   = base_x + 14'(gx);
  assign pos_dy   = base_y + 14'(gy);
  assign pos_ok   = (cur_sy < atlas_rows) && (cur_sx < atlas_cols) &&
                    (rd_addr < 27'(ATLAS_BYTES)) && !pos_dx[13] && !pos_dy[13];
  assign row_end  = (gx + 4'd1) == gw;
  assign last_pos = row_end && ((gy + 4'd1) == gh);
  assign cov_re   = (state == ST_WALK) && en && pos_ok;

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_fire && (in_kind == KIND_DRAW)) begin
          state_next = lk_hit ? ST_SETUP : ST_FINISH;
        end
      end
      ST_SETUP: begin
        if ((atlas_cols == '0) || (atlas_rows == '0) || (g_rd.w == '0) || (g_rd.h == '0)) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (en && last_pos) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p2_valid && !p3_valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // glyph walk counters
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_fire) begin
      pen_x <= in_pen_x;
      pen_y <= in_pen_y;
      adv   <= '0;
    end
    if (state == ST_SETUP) begin
      adv      <= (g_rd.adv != '0) ? g_rd.adv : {4'b0, g_rd.w};
      gw       <= g_rd.w;
      gh       <= g_rd.h;
      g_col    <= g_rd.col;
      gx       <= '0;
      gy       <= '0;
      cur_sx   <= {1'b0, g_rd.col};
      cur_sy   <= {1'b0, g_rd.row};
      row_addr <= row_mult;
      base_x   <= {2'b00, pen_x} + {{6{g_rd.ox[7]}}, g_rd.ox};
      base_y   <= {2'b00, pen_y} + {{6{g_rd.oy[7]}}, g_rd.oy};
    end
    if (state == ST_WALK && en) begin
      if (row_end) begin
        gx       <= '0;
        cur_sx   <= {1'b0, g_col};
        gy       <= gy + 4'd1;
        cur_sy   <= cur_sy + 13'd1;
        row_addr <= row_addr + 26'(atlas_cols);
      end else begin
        gx     <= gx + 4'd1;
        cur_sx <= cur_sx + 13'd1;
      end
    end
  end

  assign alpha_sum   = 17'(p3_prod) + ALPHA_ROUND;
  assign alpha_q     = alpha_sum + 17'd1 + (alpha_sum >> 8);
  assign p3_alpha    = alpha_q[15:8];
  assign px_fire     = en && p3_valid && (p3_alpha != '0);
  assign finish_load = (state == ST_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid      <= 1'b0;
      p3_valid      <= 1'b0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (en) begin
        p2_valid <= (state == ST_WALK) && pos_ok;
        p3_valid <= p2_valid;
      end
      if (px_fire) begin
        pend_valid <= 1'b1;
      end else if (finish_load) begin
        pend_valid <= 1'b0;
      end
      if ((px_fire && pend_valid) || finish_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_dx   <= pos_dx[12:0];
      p2_dy   <= pos_dy[12:0];
      p3_dx   <= p2_dx;
      p3_dy   <= p2_dy;
      p3_prod <= 16'(cov_rdata) * 16'(text_alpha);
    end
    if (px_fire) begin
      pend_x     <= p3_dx;
      pend_y     <= p3_dy;
      pend_alpha <= p3_alpha;
    end
    if (px_fire && pend_valid) begin
      out_pv    <= 1'b1;
      out_x     <= pend_x;
      out_y     <= pend_y;
      out_rgb   <= text_rgb;
      out_alpha <= pend_alpha;
      out_adv   <= adv;
      out_last  <= 1'b0;
    end else if (finish_load) begin
      out_pv    <= pend_valid;
      out_x     <= pend_valid ? pend_x : '0;
      out_y     <= pend_valid ? pend_y : '0;
      out_rgb   <= pend_valid ? text_rgb : '0;
      out_alpha <= pend_valid ? pend_alpha : '0;
      out_adv   <= adv;
      out_last  <= 1'b1;
    end
  end

  assign m_axis_tdata = {6'b0, out_adv, out_alpha, out_rgb, out_y, out_x};
  assign m_axis_tuser = out_pv;
  assign m_axis_tlast = out_last;

endmodule

// ===== rtl/gab_checker.sv =====
`timescale 1ns / 1ps
module gab_checker
  import gab_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]            m_axis_tuser,
  input logic                  m_axis_tlast
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid right after reset");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("empty draw word without last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[OUT_ADV_LSB-1:0] == '0))
    else $error("empty draw word carries pixel data");

  a_alpha_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[OUT_ADV_LSB-1:OUT_ALPHA_LSB] != '0))
    else $error("pixel word with zero alpha");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled output word changed");

endmodule

bind glyph_atlas_blitter_unit gab_checker u_gab_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/gab_pixel_checker.sv =====
`timescale 1ns / 1ps
module gab_pixel_checker
  import gab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // slot, byte_in, src_col, src_row, glyph_w, glyph_h, offset_x, offset_y, advance_in,
  // pen_x, pen_y
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_x, pixel_y, pixel_rgb, pixel_alpha, advance_out
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  // pixel_valid
  input  logic [0:0]            m_axis_tuser,
  input  logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct {
    logic        lit;
    logic [12:0] x;
    logic [12:0] y;
    logic [23:0] rgb;
    logic [7:0]  alpha;
    logic [7:0]  adv;
    logic        tail;
  } pixel_t;

  logic [7:0] coverage [ATLAS_BYTES_DEF];
  glyph_t     glyphs [GLYPH_SLOTS_DEF];

  logic [7:0]  first_code;
  logic [7:0]  last_code;
  logic [12:0] atlas_cols;
  logic [12:0] atlas_rows;
  logic [23:0] text_rgb;
  logic [7:0]  text_alpha;

  pixel_t pixel_q [$];

  function automatic logic [3:0] clamp_dim(logic [3:0] v);
    return (v > MAX_GLYPH_DIM_DEF) ? 4'(MAX_GLYPH_DIM_DEF) : v;
  endfunction

  function automatic int slot_for(logic [7:0] code);
    int idx;
    if (code >= first_code && code <= last_code) begin
      idx = code - first_code;
    end else if (SPACE_CODE >= first_code && SPACE_CODE <= last_code) begin
      idx = SPACE_CODE - first_code;
    end else begin
      return -1;
    end
    return (idx < GLYPH_SLOTS_DEF) ? idx : -1;
  endfunction

  task automatic predict_draw(logic [7:0] code, logic [11:0] pen_x, logic [11:0] pen_y);
    int     s, sx, sy, addr, a, dx, dy, n;
    logic [7:0] cv, adv;
    glyph_t g;
    pixel_t p;
    n = 0;
    adv = 8'd0;
    s = slot_for(code);
    if (s >= 0) begin
      g = glyphs[s];
      adv = (g.adv != 0) ? g.adv : 8'(g.w);
      if (atlas_cols != 0 && atlas_rows != 0) begin
        for (int y = 0; y < g.h; y++) begin
          sy = g.row + y;
          if (sy >= atlas_rows) continue;
          for (int x = 0; x < g.w; x++) begin
            sx = g.col + x;
            if (sx >= atlas_cols) continue;
            addr = sy * atlas_cols + sx;
            cv = (addr < ATLAS_BYTES_DEF) ? coverage[addr] : 8'd0;
            if (cv == 0) continue;
            a = (int'(cv) * int'(text_alpha) + int'(ALPHA_ROUND)) / 255;
            if (a == 0) continue;
            dx = int'(pen_x) + int'($signed(g.ox)) + x;
            dy = int'(pen_y) + int'($signed(g.oy)) + y;
            if (dx < 0 || dy < 0) continue;
            p.lit = 1'b1;
            p.x = dx[12:0];
            p.y = dy[12:0];
            p.rgb = text_rgb;
            p.alpha = a[7:0];
            p.adv = adv;
            p.tail = 1'b0;
            pixel_q.push_back(p);
            n++;
          end
        end
      end
    end
    if (n == 0) begin
      p.lit = 1'b0;
      p.x = '0;
      p.y = '0;
      p.rgb = '0;
      p.alpha = '0;
      p.adv = adv;
      p.tail = 1'b1;
      pixel_q.push_back(p);
    end else begin
      pixel_q[pixel_q.size()-1].tail = 1'b1;
    end
  endtask

  task automatic check_field(string fname, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    pixel_t     e;
    logic [11:0] slot;
    glyph_t     g;
    if (rst) begin
      first_code = 8'd32;
      last_code = 8'd126;
      atlas_cols = '0;
      atlas_rows = '0;
      text_rgb = 24'hFFFFFF;
      text_alpha = 8'd255;
      pixel_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FIRST_CODE: first_code = cfg_data[7:0];
          REG_LAST_CODE:  last_code = cfg_data[7:0];
          REG_ATLAS_COLS: atlas_cols = cfg_data[12:0];
          REG_ATLAS_ROWS: atlas_rows = cfg_data[12:0];
          REG_TEXT_RGB:   text_rgb = cfg_data[23:0];
          REG_TEXT_ALPHA: text_alpha = cfg_data[7:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel word expected none actual %0h/%0h/%0h", $time,
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end else begin
          e = pixel_q.pop_front();
          check_field("pixel_valid", e.lit, m_axis_tuser[0]);
          check_field("pixel_x", e.x, m_axis_tdata[12:0]);
          check_field("pixel_y", e.y, m_axis_tdata[25:13]);
          check_field("pixel_rgb", e.rgb, m_axis_tdata[49:26]);
          check_field("pixel_alpha", e.alpha, m_axis_tdata[OUT_ALPHA_LSB +: 8]);
          check_field("advance_out", e.adv, m_axis_tdata[OUT_ADV_LSB +: 8]);
          check_field("last", e.tail, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        slot = s_axis_tdata[11:0];
        case (s_axis_tuser)
          KIND_ATLAS: begin
            if (slot < ATLAS_BYTES_DEF) coverage[slot] = s_axis_tdata[19:12];
          end
          KIND_GLYPH: begin
            if (slot < GLYPH_SLOTS_DEF) begin
              g.col = s_axis_tdata[31:20];
              g.row = s_axis_tdata[43:32];
              g.w = clamp_dim(s_axis_tdata[47:44]);
              g.h = clamp_dim(s_axis_tdata[51:48]);
              g.ox = s_axis_tdata[59:52];
              g.oy = s_axis_tdata[67:60];
              g.adv = s_axis_tdata[75:68];
              glyphs[slot] = g;
            end
          end
          KIND_DRAW: predict_draw(s_axis_tdata[19:12], s_axis_tdata[87:76], s_axis_tdata[99:88]);
          default: ;
        endcase
      end
    end
    outstanding = pixel_q.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import gab_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int ATLAS_FILL = 128;
  localparam int GLYPH_FILL = 32;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet = 0;
  int cur_first = 32;
  int cur_last = 126;

  always #6 clk = ~clk;

  glyph_atlas_blitter_unit i_dut (.*);

  gab_pixel_checker i_checker (.*);

  always @(negedge clk) m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL glyph_atlas_blitter_unit");
        $finish;
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_word(int slot, int code, int col, int row,
                                                      int w, int h, int ox, int oy, int adv,
                                                      int px, int py);
    return {4'd0, 12'(py), 12'(px), 8'(adv), 8'(oy), 8'(ox), 4'(h), 4'(w), 12'(row),
            12'(col), 8'(code), 12'(slot)};
  endfunction

  function automatic int rand_cov();
    return ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255);
  endfunction

  task automatic send(logic [1:0] kind, logic [IN_DATA_W-1:0] word);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    s_axis_tuser <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_atlas(int addr, int b);
    send(KIND_ATLAS, pack_word(addr, b, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic put_glyph(int slot, int col, int row, int w, int h, int ox, int oy, int adv);
    send(KIND_GLYPH, pack_word(slot, 0, col, row, w, h, ox, oy, adv, 0, 0));
  endtask

  task automatic put_draw(int code, int px, int py);
    send(KIND_DRAW, pack_word(0, code, 0, 0, 0, 0, 0, 0, 0, px, py));
  endtask

  task automatic put_random_glyph(int slot);
    if ($urandom_range(0, 4) == 0)
      put_glyph(slot, $urandom_range(0, 4095), $urandom_range(1, 4095), $urandom_range(0, 15),
                $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255));
    else
      put_glyph(slot, $urandom_range(0, 70), $urandom_range(0, 70), $urandom_range(1, 8),
                $urandom_range(1, 8), int'($urandom_range(0, 16)) - 8,
                int'($urandom_range(0, 16)) - 8,
                ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 255));
  endtask

  // hold input low until every pending word is out, then let the block settle
  task automatic drain(int hold);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (hold) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, int value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= CFG_DATA_W'(value);
    @(negedge clk);
  endtask

  task automatic set_regs(int fc, int lc, int cols, int rows, int rgb, int alpha);
    drain(80);
    write_reg(REG_FIRST_CODE, fc);
    write_reg(REG_LAST_CODE, lc);
    write_reg(REG_ATLAS_COLS, cols);
    write_reg(REG_ATLAS_ROWS, rows);
    write_reg(REG_TEXT_RGB, rgb);
    write_reg(REG_TEXT_ALPHA, alpha);
    cfg_we <= 1'b0;
    cur_first = fc;
    cur_last = lc;
  endtask

  initial begin
    int r, code, px, py;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // fill the first ATLAS_FILL atlas bytes and the first GLYPH_FILL table slots
    for (int a = 0; a < ATLAS_FILL; a++) put_atlas(a, rand_cov());
    for (int s = 0; s < GLYPH_FILL; s++) put_random_glyph(s);

    put_draw(40, 10, 10);
    set_regs(32, 63, 16, 8, 24'h123456, 255);
    put_glyph(1, 0, 0, 8, 8, 0, 0, 0);
    put_draw(33, 4095, 4095);
    put_glyph(2, 8, 0, 15, 9, 127, 127, 255);
    put_draw(34, 4095, 4095);
    put_glyph(3, 0, 0, 8, 8, -128, -128, 1);
    put_draw(35, 0, 0);
    put_draw(35, 124, 130);
    put_glyph(4, 0, 0, 0, 5, 0, 0, 0);
    put_draw(36, 30, 30);
    put_glyph(5, 4095, 4095, 8, 8, 0, 0, 3);
    put_draw(37, 30, 30);
    put_draw(200, 50, 50);
    put_draw(0, 50, 50);
    send(KIND_UNUSED, {IN_DATA_W{1'b1}});
    put_glyph(4095, 4095, 4095, 15, 15, 255, 255, 255);
    put_atlas(4095, 255);
    put_atlas(0, 0);
    put_draw(33, 10, 10);
    set_regs(65, 90, 16, 8, 0, 1);
    put_draw(66, 20, 20);
    put_draw(10, 20, 20);
    set_regs(0, 31, 4096, 4096, 24'hFFFFFF, 0);
    put_draw(3, 5, 5);
    set_regs(0, 31, 4096, 4096, 24'hABCDEF, 200);
    put_glyph(6, 0, 0, 8, 8, 0, 0, 0);
    put_draw(6, 5, 5);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_regs(32, 63, 16, 8, $urandom_range(0, 24'hFFFFFF), 255);
        1: set_regs(0, 31, 4096, 4096, 0, 200);
        2: set_regs(32, 32, 1, 128, 24'hFFFFFF, 128);
        3: set_regs(20, 40, 128, 1, $urandom_range(0, 24'hFFFFFF), 77);
        default: set_regs(200, 10, 0, 64, 24'hFFFFFF, 255);
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      for (int i = 0; i < 25; i++) begin
        if (ph == 1 && i == 12) drain(0);
        r = $urandom_range(0, 99);
        if (r < 55) begin
          if (cur_first <= cur_last && $urandom_range(0, 3) != 0)
            code = $urandom_range(cur_first, cur_last);
          else
            code = $urandom_range(0, 255);
          px = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 200);
          py = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 200);
          put_draw(code, px, py);
        end else if (r < 75) begin
          put_random_glyph(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, 255));
        end else if (r < 95) begin
          put_atlas($urandom_range(0, 4095), rand_cov());
        end else begin
          send(KIND_UNUSED, IN_DATA_W'({$urandom, $urandom, $urandom, $urandom}));
        end
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    drain(100);
    if (mismatches == 0 && outstanding == 0)
      $display("PASS glyph_atlas_blitter_unit");
    else
      $display("FAIL glyph_atlas_blitter_unit");
    $finish;
  end

endmodule
